// ===== hw/rtl/mrm_pkg.sv =====
`timescale 1ns / 1ps

package mrm_pkg;

  // Default fixed-point format: signed Q16.16 in a 32-bit element.
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned ELEM_WIDTH_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Port width of every element and the matrix dimension.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned N      = 4;

  // Item class decided in the front part.
  typedef enum logic {
    OP_MUL  = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // One classified item as it travels through the queue. Elements are
  // already sign-extended from the element width to the port width.
  typedef struct packed {
    op_e                          op;
    logic [1:0]                   row;
    logic [N-1:0][DATA_W-1:0]     elem;
  } item_t;

  // Sign-extend the low ew bits of x to the full port width.
  function automatic logic signed [DATA_W-1:0] sext_elem(input logic [DATA_W-1:0] x,
                                                         input int unsigned ew);
    logic [DATA_W-1:0] t;
    t = x << (DATA_W - ew);
    return $signed(t) >>> (DATA_W - ew);
  endfunction

endpackage

// ===== hw/rtl/mrm_front.sv =====
`timescale 1ns / 1ps

module mrm_front #(
  parameter int unsigned ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [1:0]             row_index_i,
  input  logic [mrm_pkg::N-1:0][mrm_pkg::DATA_W-1:0] elem_i,
  output logic                   push_o,
  input  logic                   push_ready_i,
  output mrm_pkg::item_t         item_o
);

  logic           valid_q, valid_d;
  mrm_pkg::item_t item_q, item_d;
  logic           in_xfer;

  // The input register frees up whenever its item moves into the queue.
  assign in_ready_o = !valid_q || push_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign push_o     = valid_q;
  assign item_o     = item_q;

  // Classify the item and sign-extend its elements from the element width.
  always_comb begin
    item_d.op  = kind_i ? mrm_pkg::OP_LOAD : mrm_pkg::OP_MUL;
    item_d.row = row_index_i;
    for (int j = 0; j < mrm_pkg::N; j++) begin
      item_d.elem[j] = mrm_pkg::sext_elem(elem_i[j], ELEM_WIDTH);
    end
    valid_d = in_xfer || (valid_q && !push_ready_i);
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hw/rtl/mrm_fifo.sv =====
`timescale 1ns / 1ps

module mrm_fifo #(
  parameter int unsigned DEPTH = mrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  mrm_pkg::item_t push_item_i,
  output logic           valid_o,
  input  logic           pop_i,
  output mrm_pkg::item_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mrm_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o      = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && valid_o;

  // Pointer and fill-count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  // A pop is only requested while an entry is present.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  // A lone pop lowers the fill count by exactly one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not follow a pop");

endmodule

// ===== hw/rtl/mrm_back.sv =====
`timescale 1ns / 1ps

module mrm_back #(
  parameter int unsigned FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF,
  parameter int unsigned ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  mrm_pkg::item_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     out_row_o,
  output logic [mrm_pkg::N-1:0][mrm_pkg::DATA_W-1:0] prod_o,
  output logic           overflow_o
);

  localparam int unsigned EW     = ELEM_WIDTH;
  localparam int unsigned PROD_W = 2 * EW;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic [mrm_pkg::DATA_W-1:0] ONE_RAW = mrm_pkg::DATA_W'(1) << FRAC_BITS;
  localparam logic signed [mrm_pkg::DATA_W-1:0] DIAG_EXT =
    mrm_pkg::sext_elem(ONE_RAW, EW);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  // Right-hand matrix, held in the element width.
  logic signed [EW-1:0]     mat_q [mrm_pkg::N][mrm_pkg::N];

  // Stage 1: the sixteen products.
  logic                     valid1_q, valid1_d;
  logic [1:0]               row1_q;
  logic signed [PROD_W-1:0] prod1_q [mrm_pkg::N][mrm_pkg::N];

  // Stage 2: two pair sums per column.
  logic                     valid2_q;
  logic [1:0]               row2_q;
  logic signed [PAIR_W-1:0] pair2_q [mrm_pkg::N][2];

  // Output register.
  logic                     out_valid_q;
  logic [1:0]               out_row_q;
  logic [mrm_pkg::N-1:0][mrm_pkg::DATA_W-1:0] prod_q, prod_d;
  logic                     ovf_q, ovf_d;

  logic                     advance;
  logic                     is_load;
  logic signed [EW-1:0]     left [mrm_pkg::N];
  logic signed [SUM_W-1:0]  total [mrm_pkg::N];
  logic signed [SUM_W-1:0]  shifted [mrm_pkg::N];
  logic signed [EW-1:0]     sat [mrm_pkg::N];

  // The pipeline moves whenever the output register is free or being taken.
  // A load only updates the matrix, so it leaves the queue even during a stall.
  assign advance  = !out_valid_q || out_ready_i;
  assign is_load  = (head_i.op == mrm_pkg::OP_LOAD);
  assign pop_o    = head_valid_i && (is_load || advance);
  assign valid1_d = pop_o && !is_load;

  always_comb begin
    for (int k = 0; k < mrm_pkg::N; k++) begin
      left[k] = $signed(head_i.elem[k][EW-1:0]);
    end
  end

  // Column sum, floor shift and saturation for the output stage.
  always_comb begin
    ovf_d = 1'b0;
    for (int j = 0; j < mrm_pkg::N; j++) begin
      total[j]   = SUM_W'(pair2_q[j][0]) + SUM_W'(pair2_q[j][1]);
      shifted[j] = total[j] >>> FRAC_BITS;
      if (shifted[j] > SAT_MAX) begin
        sat[j] = SAT_MAX[EW-1:0];
        ovf_d  = 1'b1;
      end else if (shifted[j] < SAT_MIN) begin
        sat[j] = SAT_MIN[EW-1:0];
        ovf_d  = 1'b1;
      end else begin
        sat[j] = shifted[j][EW-1:0];
      end
      prod_d[j] = mrm_pkg::sext_elem(mrm_pkg::DATA_W'($unsigned(sat[j])), EW);
    end
  end

  // Matrix storage: identity after reset, one row rewritten per load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mrm_pkg::N; r++) begin
        for (int c = 0; c < mrm_pkg::N; c++) begin
          mat_q[r][c] <= (r == c) ? DIAG_EXT[EW-1:0] : '0;
        end
      end
    end else if (pop_o && is_load) begin
      for (int c = 0; c < mrm_pkg::N; c++) begin
        mat_q[head_i.row][c] <= left[c];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid1_q    <= valid1_d;
      valid2_q    <= valid1_q;
      out_valid_q <= valid2_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      row1_q <= head_i.row;
      for (int k = 0; k < mrm_pkg::N; k++) begin
        for (int j = 0; j < mrm_pkg::N; j++) begin
          prod1_q[k][j] <= left[k] * mat_q[k][j];
        end
      end
      row2_q <= row1_q;
      for (int j = 0; j < mrm_pkg::N; j++) begin
        pair2_q[j][0] <= PAIR_W'(prod1_q[0][j]) + PAIR_W'(prod1_q[1][j]);
        pair2_q[j][1] <= PAIR_W'(prod1_q[2][j]) + PAIR_W'(prod1_q[3][j]);
      end
      out_row_q <= row2_q;
      prod_q    <= prod_d;
      ovf_q     <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign prod_o      = prod_q;
  assign overflow_o  = ovf_q;

  // A load that leaves the queue while the pipeline moves adds no stage entry.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_load && advance) |=> !valid1_q)
    else $error("load item entered the product stage");

  // While the output is stalled the product stage keeps its item.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid1_q) && $stable(valid2_q))
    else $error("pipeline moved during a stall");

  // A multiply in the sum stage reaches the output on the next move.
  a_sum_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid2_q && advance) |=> out_valid_q)
    else $error("result lost between sum stage and output");

endmodule

// ===== hw/rtl/matrix4x4_row_multiplier_core.sv =====
`timescale 1ns / 1ps

// Row-by-matrix multiplier for signed fixed-point 4x4 matrices. A load item
// (kind 1) replaces one row of the stored right-hand matrix, which starts out
// as the identity, and gives no result; a multiply item (kind 0) carries one
// left-hand row and returns the product row, each element summed exactly,
// shifted right by FRAC_BITS toward minus infinity and saturated to
// ELEM_WIDTH bits, with overflow set if any element saturated. One item is
// taken every cycle: the input register, the queue and the three back-end
// stages (products, pair sums, final sum and saturation into the output
// register) each move one row per clock, so the rate is one row per cycle
// for as long as results are taken. A multiply result passes through the input
// register, the queue and the three back-end stages. Loads take effect in item order,
// so a multiply always sees every load transferred ahead of it.
module matrix4x4_row_multiplier_core #(
  parameter int unsigned FRAC_BITS   = mrm_pkg::FRAC_BITS_DEF,
  parameter int unsigned ELEM_WIDTH  = mrm_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = mrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [1:0]  row_index_i,
  input  logic [31:0] elem_0_i,
  input  logic [31:0] elem_1_i,
  input  logic [31:0] elem_2_i,
  input  logic [31:0] elem_3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_row_o,
  output logic [31:0] prod_0_o,
  output logic [31:0] prod_1_o,
  output logic [31:0] prod_2_o,
  output logic [31:0] prod_3_o,
  output logic        overflow_o
);

  logic [mrm_pkg::N-1:0][mrm_pkg::DATA_W-1:0] elem_in;
  logic [mrm_pkg::N-1:0][mrm_pkg::DATA_W-1:0] prod_out;
  logic           push, push_ready, head_valid, pop;
  mrm_pkg::item_t push_item, head_item;

  assign elem_in[0] = elem_0_i;
  assign elem_in[1] = elem_1_i;
  assign elem_in[2] = elem_2_i;
  assign elem_in[3] = elem_3_i;

  // Front part: input register and classification.
  mrm_front #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .row_index_i  (row_index_i),
    .elem_i       (elem_in),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  // Queue between the two parts.
  mrm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .valid_o      (head_valid),
    .pop_i        (pop),
    .head_o       (head_item)
  );

  // Back part: matrix store and arithmetic pipeline.
  mrm_back #(
    .FRAC_BITS  (FRAC_BITS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .prod_o       (prod_out),
    .overflow_o   (overflow_o)
  );

  assign prod_0_o = prod_out[0];
  assign prod_1_o = prod_out[1];
  assign prod_2_o = prod_out[2];
  assign prod_3_o = prod_out[3];

endmodule
